/* design/cfd_pkg.sv */
// Shared types and constants for the cell stream deframer.
`timescale 1ns / 1ps
package cfd_pkg;

  localparam int LENGTH_BITS_DEF = 32;
  localparam int CFG_INDEX_W     = 8;
  localparam int QUEUE_DEPTH     = 4;
  localparam int HEADER_BYTES    = 1 + 4 + 4;

  // header byte positions: type at 0, sequence at 1..4, length at 5..8
  localparam logic [3:0] LAST_SEQ_BYTE = 4'd4;
  localparam logic [3:0] LAST_HDR_BYTE = 4'(HEADER_BYTES - 1);

  localparam logic [7:0] DATA_TYPE_RESET    = 8'hFE;
  localparam logic [7:0] COMMAND_TYPE_RESET = 8'hED;

  localparam logic [CFG_INDEX_W-1:0] REG_DATA_TYPE    = CFG_INDEX_W'(0);
  localparam logic [CFG_INDEX_W-1:0] REG_COMMAND_TYPE = CFG_INDEX_W'(1);

  localparam logic ERR_BAD_TYPE  = 1'b0;
  localparam logic ERR_TRUNCATED = 1'b1;

  typedef enum logic [1:0] {
    KIND_HEADER  = 2'd0,
    KIND_PAYLOAD = 2'd1,
    KIND_ERROR   = 2'd2
  } kind_t;

  // One classified input beat: an optional main result and an optional
  // truncation error that follows it. Both share the held header fields.
  typedef struct packed {
    logic        has_main;
    kind_t       main_kind;
    logic        main_last;
    logic        has_trunc;
    logic [7:0]  cell_type;
    logic [31:0] seq;
    logic [31:0] len;
    logic [7:0]  pbyte;
  } rec_t;

endpackage

/* design/cfd_front.sv */
// Front end: config registers, header parser and payload counter.
`timescale 1ns / 1ps
module cfd_front #(
  parameter int LENGTH_BITS = cfd_pkg::LENGTH_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [cfd_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [7:0]                       cfg_data,
  input  logic                             accept,
  input  logic [7:0]                       stream_byte,
  input  logic                             end_of_buffer,
  output logic                             rec_push,
  output cfd_pkg::rec_t                    rec
);

  typedef enum logic [1:0] {
    PH_HEADER  = 2'd0,
    PH_PAYLOAD = 2'd1,
    PH_DISCARD = 2'd2
  } phase_t;

  localparam logic [31:0] LEN_MASK = 32'((64'd1 << LENGTH_BITS) - 64'd1);

  logic [7:0]             data_code_r, cmd_code_r;
  phase_t                 phase_r, phase_nxt;
  logic [3:0]             cnt_r, cnt_nxt;
  logic [7:0]             type_r, type_nxt;
  logic [31:0]            seq_r, seq_nxt;
  logic [31:0]            len_r, len_nxt;
  logic [LENGTH_BITS-1:0] rem_r, rem_nxt;
  logic [LENGTH_BITS-1:0] rem_dec;
  logic [31:0]            len_shift, len_masked;
  logic                   owed;
  logic                   has_main, main_last;
  cfd_pkg::kind_t         main_kind;
  logic [7:0]             pbyte;

  always_comb begin
    phase_nxt  = phase_r;
    cnt_nxt    = cnt_r;
    type_nxt   = type_r;
    seq_nxt    = seq_r;
    len_nxt    = len_r;
    rem_nxt    = rem_r;
    owed       = 1'b0;
    has_main   = 1'b0;
    main_kind  = cfd_pkg::KIND_HEADER;
    main_last  = 1'b0;
    pbyte      = 8'd0;
    rem_dec    = rem_r - 1'b1;
    len_shift  = {len_r[23:0], stream_byte};
    len_masked = len_shift & LEN_MASK;
    case (phase_r)
      PH_PAYLOAD: begin
        rem_nxt   = rem_dec;
        has_main  = 1'b1;
        main_kind = cfd_pkg::KIND_PAYLOAD;
        pbyte     = stream_byte;
        if (rem_dec == '0) begin
          main_last = 1'b1;
          phase_nxt = PH_HEADER;
          cnt_nxt   = 4'd0;
        end else begin
          owed = 1'b1;
        end
      end
      PH_DISCARD: begin
      end
      default: begin
        if (cnt_r == 4'd0) begin
          type_nxt = stream_byte;
          seq_nxt  = 32'd0;
          len_nxt  = 32'd0;
          if (stream_byte != data_code_r && stream_byte != cmd_code_r) begin
            has_main  = 1'b1;
            main_kind = cfd_pkg::KIND_ERROR;
            main_last = 1'b1;
            phase_nxt = PH_DISCARD;
          end else begin
            cnt_nxt = 4'd1;
            owed    = 1'b1;
          end
        end else if (cnt_r <= cfd_pkg::LAST_SEQ_BYTE) begin
          seq_nxt = {seq_r[23:0], stream_byte};
          cnt_nxt = cnt_r + 4'd1;
          owed    = 1'b1;
        end else if (cnt_r >= cfd_pkg::LAST_HDR_BYTE) begin
          len_nxt   = len_masked;
          cnt_nxt   = 4'd0;
          has_main  = 1'b1;
          main_kind = cfd_pkg::KIND_HEADER;
          if (len_masked == 32'd0) begin
            main_last = 1'b1;
            phase_nxt = PH_HEADER;
          end else begin
            rem_nxt   = len_masked[LENGTH_BITS-1:0];
            phase_nxt = PH_PAYLOAD;
            owed      = 1'b1;
          end
        end else begin
          len_nxt = len_shift;
          cnt_nxt = cnt_r + 4'd1;
          owed    = 1'b1;
        end
      end
    endcase
    if (end_of_buffer) begin
      phase_nxt = PH_HEADER;
      cnt_nxt   = 4'd0;
      rem_nxt   = '0;
    end
  end

  // results carry the held fields as updated by this beat
  always_comb begin
    rec.has_main  = has_main;
    rec.main_kind = main_kind;
    rec.main_last = main_last;
    rec.has_trunc = end_of_buffer & owed;
    rec.cell_type = type_nxt;
    rec.seq       = seq_nxt;
    rec.len       = len_nxt;
    rec.pbyte     = pbyte;
  end

  assign rec_push = accept & (rec.has_main | rec.has_trunc);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      data_code_r <= cfd_pkg::DATA_TYPE_RESET;
      cmd_code_r  <= cfd_pkg::COMMAND_TYPE_RESET;
      phase_r     <= PH_HEADER;
      cnt_r       <= 4'd0;
      type_r      <= 8'd0;
      seq_r       <= 32'd0;
      len_r       <= 32'd0;
      rem_r       <= '0;
    end else begin
      if (cfg_we && cfg_index == cfd_pkg::REG_DATA_TYPE) begin
        data_code_r <= cfg_data;
      end
      if (cfg_we && cfg_index == cfd_pkg::REG_COMMAND_TYPE) begin
        cmd_code_r <= cfg_data;
      end
      if (accept) begin
        phase_r <= phase_nxt;
        cnt_r   <= cnt_nxt;
        type_r  <= type_nxt;
        seq_r   <= seq_nxt;
        len_r   <= len_nxt;
        rem_r   <= rem_nxt;
      end
    end
  end

endmodule

/* design/cfd_queue.sv */
// Short record queue between the parser and the result stage.
`timescale 1ns / 1ps
module cfd_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          wr_en,
  input  cfd_pkg::rec_t wr_data,
  output logic          full,
  input  logic          rd_en,
  output cfd_pkg::rec_t rd_data,
  output logic          empty
);

  localparam int PTR_W = $clog2(cfd_pkg::QUEUE_DEPTH);
  localparam int CNT_W = $clog2(cfd_pkg::QUEUE_DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(cfd_pkg::QUEUE_DEPTH - 1);
  localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(cfd_pkg::QUEUE_DEPTH);

  cfd_pkg::rec_t    mem_r [cfd_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] cnt_r;
  logic             do_wr, do_rd;

  assign full    = (cnt_r == DEPTH_CNT);
  assign empty   = (cnt_r == '0);
  assign do_wr   = wr_en & ~full;
  assign do_rd   = rd_en & ~empty;
  assign rd_data = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr_r <= (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_rd) begin
        rd_ptr_r <= (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_wr && !do_rd) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (do_rd && !do_wr) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

endmodule

/* design/cfd_back.sv */
// Result stage: unpacks each record into one or two output beats.
`timescale 1ns / 1ps
module cfd_back (
  input  logic          clk,
  input  logic          rst_n,
  input  cfd_pkg::rec_t head,
  input  logic          q_empty,
  output logic          q_pop,
  output logic          out_empty,
  input  logic          out_pop,
  output logic [1:0]    out_result_kind,
  output logic [7:0]    out_cell_type,
  output logic [31:0]   out_sequence_number,
  output logic [31:0]   out_payload_length,
  output logic [7:0]    out_payload_byte,
  output logic          out_last_of_cell,
  output logic          out_error_code
);

  cfd_pkg::rec_t rec_r;
  logic          valid_r;
  logic          sel_r;    // showing the trailing truncation error
  logic          taken, done, advance, load;

  assign taken   = valid_r & out_pop;
  assign done    = taken & (sel_r | ~rec_r.has_trunc);
  assign advance = taken & ~sel_r & rec_r.has_trunc;
  assign load    = ~valid_r | done;
  assign q_pop   = load & ~q_empty;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      sel_r   <= 1'b0;
    end else if (q_pop) begin
      valid_r <= 1'b1;
      sel_r   <= ~head.has_main;
    end else if (done) begin
      valid_r <= 1'b0;
    end else if (advance) begin
      sel_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      rec_r <= head;
    end
  end

  assign out_empty           = ~valid_r;
  assign out_result_kind     = sel_r ? cfd_pkg::KIND_ERROR : rec_r.main_kind;
  assign out_cell_type       = rec_r.cell_type;
  assign out_sequence_number = rec_r.seq;
  assign out_payload_length  = rec_r.len;
  assign out_payload_byte    = sel_r ? 8'd0 : rec_r.pbyte;
  assign out_last_of_cell    = sel_r | rec_r.main_last;
  assign out_error_code      = sel_r ? cfd_pkg::ERR_TRUNCATED : cfd_pkg::ERR_BAD_TYPE;

endmodule

/* design/cell_stream_deframer_unit.sv */
// Cell stream deframer: splits a byte stream into header, payload and error beats.
// A result passes the record queue and then the output register before reaching the out_ ports.
// Throughput: one input beat per cycle; the parser never holds the input, so it stalls only
//   when the four-entry record queue is full. Output is one beat per cycle while out_pop is
//   high and records wait; a byte that ends a buffer early adds a trailing truncation beat.
// Reset (rst_n low, synchronous): parser back to header phase, held fields zeroed,
//   type codes to 0xFE / 0xED, queue and output stage emptied.
`timescale 1ns / 1ps
module cell_stream_deframer_unit #(
  parameter int LENGTH_BITS = cfd_pkg::LENGTH_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_push,
  output logic                            in_full,
  input  logic [7:0]                      in_stream_byte,
  input  logic                            in_end_of_buffer,
  output logic                            out_empty,
  input  logic                            out_pop,
  output logic [1:0]                      out_result_kind,
  output logic [7:0]                      out_cell_type,
  output logic [31:0]                     out_sequence_number,
  output logic [31:0]                     out_payload_length,
  output logic [7:0]                      out_payload_byte,
  output logic                            out_last_of_cell,
  output logic                            out_error_code,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [cfd_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [7:0]                      cfg_data
);

  logic          accept;
  logic          rec_push;
  cfd_pkg::rec_t rec, head;
  logic          q_full, q_empty, q_pop;

  assign cfg_ready = 1'b1;
  assign in_full   = q_full;
  assign accept    = in_push & ~q_full;

  cfd_front #(
    .LENGTH_BITS(LENGTH_BITS)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_valid & cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .accept       (accept),
    .stream_byte  (in_stream_byte),
    .end_of_buffer(in_end_of_buffer),
    .rec_push     (rec_push),
    .rec          (rec)
  );

  cfd_queue u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .wr_en  (rec_push),
    .wr_data(rec),
    .full   (q_full),
    .rd_en  (q_pop),
    .rd_data(head),
    .empty  (q_empty)
  );

  cfd_back u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .head               (head),
    .q_empty            (q_empty),
    .q_pop              (q_pop),
    .out_empty          (out_empty),
    .out_pop            (out_pop),
    .out_result_kind    (out_result_kind),
    .out_cell_type      (out_cell_type),
    .out_sequence_number(out_sequence_number),
    .out_payload_length (out_payload_length),
    .out_payload_byte   (out_payload_byte),
    .out_last_of_cell   (out_last_of_cell),
    .out_error_code     (out_error_code)
  );

endmodule
